// ===== rtl/core/priority_task_scheduler_assert.svh =====
// Assertion macros for the task scheduler
`ifndef PRIORITY_TASK_SCHEDULER_ASSERT_SVH
`define PRIORITY_TASK_SCHEDULER_ASSERT_SVH
// implication checked every clock outside reset
`define PTS_ASSERT_IMP(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication
`define PTS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ===== rtl/core/pts_pkg.sv =====
// Package: types and constants for the task scheduler
`timescale 1ns / 1ps
package pts_pkg;
  localparam int MaxTasks = 8;
  localparam int SlotW = 3;
  localparam int CntW = 4;

  typedef enum logic [2:0] {
    CMD_WAIT = 3'd0, CMD_SLEEP = 3'd1, CMD_WAKE = 3'd2, CMD_SIGNAL = 3'd3, CMD_LAUNCH = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0, ST_ACTIVE = 2'd1, ST_WAIT = 2'd2, ST_SLEEP = 2'd3
  } slot_state_t;

  typedef enum logic [2:0] {
    S_IDLE, S_PARK, S_SCAN, S_APPLY, S_SCAN2, S_APPLY2, S_OUT
  } fsm_state_t;

  typedef enum logic [1:0] {
    SCAN_ACTIVE, SCAN_SLEEP, SCAN_CHAN
  } scan_kind_t;

  typedef struct packed {
    logic       load;
    logic       park;
    logic       scan_start;
    logic       scan_step;
    scan_kind_t scan_kind;
    logic       apply;
    logic       apply_wake2;
    logic       out_load;
  } ctrl_t;

  typedef struct packed {
    logic scan_done;
    logic need_scan;
    logic need_wake;
  } stat_t;
endpackage

// ===== rtl/core/pts_if.sv =====
// Valid/ready word channel interface
`timescale 1ns / 1ps
interface pts_if #(parameter int W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/priority_task_scheduler.sv =====
// Top level of the priority task scheduler
//  channel | dir | word
//  in_     | in  | command, task_slot, channel, due_time, priority_req
//  out_    | out | current_task .. rejected
//  cfg_    | in  | main_priority
// A command steps through park, list walk, apply, second walk, second apply and output.
// Each list walk follows the slot links from slot 0; wait and sleep walk twice.
// Wake and launch skip the walk unless a wake disarms the timer sleeper.
// Reset is synchronous; slot 0 runs active after it.
// One command is in flight; in_ready is low until its result is registered.
// A held result stalls only the final output step.
`timescale 1ns / 1ps
module priority_task_scheduler import pts_pkg::*; (
  input logic clk,
  input logic rst_n,
  pts_if.sink   in_if,
  pts_if.source out_if,
  pts_if.sink   cfg_if
);
  ctrl_t ctrl;
  stat_t stat;

  assign cfg_if.ready = 1'b1;

  pts_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .cmd(cmd_t'(in_if.data[2:0])), .stat, .ctrl
  );

  pts_dp u_dp (
    .clk, .rst_n,
    .cfg_we(cfg_if.valid), .cfg_data(cfg_if.data[7:0]),
    .in_data(in_if.data[61:0]), .ctrl, .stat, .out_data(out_if.data[44:0])
  );
endmodule

// ===== rtl/core/pts_ctrl.sv =====
// Controller state machine for the task scheduler
`timescale 1ns / 1ps
`include "priority_task_scheduler_assert.svh"
module pts_ctrl import pts_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  cmd_t  cmd,
  input  stat_t stat,
  output ctrl_t ctrl
);
  fsm_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  cmd_t cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (state_r == S_IDLE && in_valid) cmd_r <= cmd;
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_PARK;
      S_PARK:   state_nxt = stat.need_scan ? S_SCAN : S_APPLY;
      S_SCAN:   if (stat.scan_done) state_nxt = S_APPLY;
      S_APPLY:  state_nxt = stat.need_scan ? S_SCAN2 : S_OUT;
      S_SCAN2:  if (stat.scan_done) state_nxt = S_APPLY2;
      S_APPLY2: state_nxt = S_OUT;
      S_OUT:    if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: ctrl.load = in_valid;
      S_PARK: begin
        ctrl.park = 1'b1;
        ctrl.scan_start = 1'b1;
        ctrl.scan_kind = (cmd_r == CMD_SLEEP) ? SCAN_SLEEP :
                         (cmd_r == CMD_SIGNAL) ? SCAN_CHAN : SCAN_ACTIVE;
      end
      S_SCAN: begin
        ctrl.scan_step = 1'b1;
        ctrl.scan_kind = (cmd_r == CMD_SLEEP) ? SCAN_SLEEP :
                         (cmd_r == CMD_SIGNAL) ? SCAN_CHAN : SCAN_ACTIVE;
      end
      S_APPLY: begin
        ctrl.apply = 1'b1;
        ctrl.scan_start = 1'b1;
        ctrl.scan_kind = (cmd_r == CMD_SLEEP || cmd_r == CMD_WAIT) ? SCAN_ACTIVE : SCAN_SLEEP;
      end
      S_SCAN2: begin
        ctrl.scan_step = 1'b1;
        ctrl.scan_kind = (cmd_r == CMD_SLEEP || cmd_r == CMD_WAIT) ? SCAN_ACTIVE : SCAN_SLEEP;
      end
      S_APPLY2: ctrl.apply_wake2 = 1'b1;
      S_OUT: if (!out_valid_r || out_ready) begin
        ctrl.out_load = 1'b1;
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  `PTS_ASSERT_IMP(a_ready_idle, in_ready, state_r == S_IDLE)
  `PTS_ASSERT_NEXT(a_load_park, in_valid && in_ready, state_r == S_PARK)
  `PTS_ASSERT_NEXT(a_out_set, ctrl.out_load, out_valid)
endmodule

// ===== rtl/core/pts_dp.sv =====
// Datapath: slot table, list walk and result register
`timescale 1ns / 1ps
module pts_dp import pts_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_data,
  input  logic [61:0]      in_data,
  input  ctrl_t            ctrl,
  output stat_t            stat,
  output logic [44:0]      out_data
);
  slot_state_t st_r [MaxTasks];
  logic [7:0]  pri_r [MaxTasks];
  logic [15:0] chn_r [MaxTasks];
  logic [31:0] due_r [MaxTasks];
  logic [SlotW-1:0] lnk_r [MaxTasks];
  logic [MaxTasks-1:0] lv_r;
  logic [SlotW-1:0] run_r, before_r;
  logic arm_v_r;
  logic [SlotW-1:0] arm_r;
  logic [2:0] cmd_r, t_r;
  logic [15:0] ch_r;
  logic [31:0] dt_r;
  logic [7:0] pr_r;
  logic [SlotW-1:0] cur_r, best_r;
  logic [CntW-1:0] cnt_r;
  logic found_r, done_r, woken_r, rej_r;
  logic [SlotW-1:0] wslot_r;
  logic [44:0] out_r;
  logic hit, better;
  logic [SlotW-1:0] wt;
  logic wake_ok;

  assign wt = (cmd_r == CMD_SIGNAL) ? best_r : t_r;
  assign wake_ok = (st_r[wt] == ST_SLEEP || st_r[wt] == ST_WAIT) &&
                   (cmd_r != CMD_SIGNAL || found_r);

  always_comb begin
    hit = 1'b0;
    better = 1'b0;
    case (ctrl.scan_kind)
      SCAN_ACTIVE: begin
        hit = st_r[cur_r] == ST_ACTIVE;
        better = pri_r[cur_r] > pri_r[best_r];
      end
      SCAN_SLEEP: begin
        hit = st_r[cur_r] == ST_SLEEP;
        better = due_r[cur_r] < due_r[best_r];
      end
      SCAN_CHAN: begin
        hit = (st_r[cur_r] == ST_SLEEP || st_r[cur_r] == ST_WAIT) && chn_r[cur_r] == ch_r;
        better = pri_r[cur_r] > pri_r[best_r];
      end
      default: ;
    endcase
  end

  always_comb begin
    stat.scan_done = done_r;
    stat.need_scan = 1'b0;
    if (ctrl.apply || ctrl.apply_wake2) stat.need_scan = 1'b0;
    case (cmd_r)
      CMD_WAIT, CMD_SLEEP, CMD_SIGNAL: stat.need_scan = 1'b1;
      default: ;
    endcase
    // second pass: pick the active task, or rearm after wake of the armed sleeper
    if (ctrl.apply) begin
      stat.need_scan = (cmd_r == CMD_WAIT || cmd_r == CMD_SLEEP) ? 1'b1 :
        ((cmd_r == CMD_WAKE || cmd_r == CMD_SIGNAL) &&
         wake_ok && st_r[wt] == ST_SLEEP && arm_v_r && arm_r == wt);
    end
    stat.need_wake = wake_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MaxTasks; i++) begin
        st_r[i] <= ST_FREE;
        pri_r[i] <= '0;
        chn_r[i] <= '0;
        lnk_r[i] <= '0;
      end
      st_r[0] <= ST_ACTIVE;
      lv_r <= '0;
      run_r <= '0;
      arm_v_r <= 1'b0;
      arm_r <= '0;
      done_r <= 1'b0;
    end else begin
      if (cfg_we) pri_r[0] <= cfg_data;
      if (ctrl.load) begin
        {pr_r, dt_r, ch_r, t_r, cmd_r} <= in_data;
        before_r <= run_r;
        woken_r <= 1'b0;
        rej_r <= 1'b0;
        wslot_r <= '0;
      end
      if (ctrl.park && (cmd_r == CMD_WAIT || cmd_r == CMD_SLEEP)) begin
        chn_r[run_r] <= ch_r;
        st_r[run_r] <= (cmd_r == CMD_SLEEP) ? ST_SLEEP : ST_WAIT;
        if (cmd_r == CMD_SLEEP) due_r[run_r] <= dt_r;
      end
      if (ctrl.scan_start) begin
        cur_r <= '0;
        cnt_r <= '0;
        found_r <= 1'b0;
        best_r <= '0;
        done_r <= 1'b0;
      end else if (ctrl.scan_step && !done_r) begin
        if (hit && (!found_r || better)) begin
          best_r <= cur_r;
          found_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
        cur_r <= lnk_r[cur_r];
        if (cnt_r == CntW'(MaxTasks - 1) || !lv_r[cur_r]) done_r <= 1'b1;
      end
      if (ctrl.apply) begin
        case (cmd_r)
          CMD_SLEEP: begin
            arm_v_r <= found_r;
            arm_r <= found_r ? best_r : '0;
          end
          CMD_WAKE, CMD_SIGNAL: if (wake_ok) begin
            st_r[wt] <= ST_ACTIVE;
            chn_r[wt] <= '0;
            woken_r <= 1'b1;
            wslot_r <= wt;
            if (pri_r[wt] > pri_r[run_r] || st_r[run_r] != ST_ACTIVE) run_r <= wt;
          end
          CMD_LAUNCH: begin
            if (st_r[t_r] != ST_FREE) rej_r <= 1'b1;
            else begin
              st_r[t_r] <= ST_ACTIVE;
              pri_r[t_r] <= pr_r;
              chn_r[t_r] <= '0;
              lnk_r[t_r] <= lnk_r[run_r];
              lv_r[t_r] <= lv_r[run_r];
              lnk_r[run_r] <= t_r;
              lv_r[run_r] <= 1'b1;
              run_r <= t_r;
            end
          end
          default: ;
        endcase
      end
      if (ctrl.apply_wake2) begin
        if (cmd_r == CMD_WAIT || cmd_r == CMD_SLEEP) begin
          if (found_r) run_r <= best_r;
        end else begin
          arm_v_r <= found_r;
          arm_r <= found_r ? best_r : '0;
        end
      end
      if (ctrl.out_load) begin
        out_r <= {rej_r, wslot_r, woken_r,
                  arm_v_r ? due_r[arm_r] : 32'd0,
                  arm_v_r ? arm_r : SlotW'(0), arm_v_r,
                  run_r != before_r, run_r};
      end
    end
  end

  assign out_data = out_r;
endmodule

// ===== tb/tb_priority_task_scheduler.sv =====
// Testbench: random and directed command stream checked against a scheduler predictor
`timescale 1ns / 1ps
module tb_priority_task_scheduler;
  import pts_pkg::*;

  typedef struct packed {
    logic [7:0]  prio;
    logic [31:0] due;
    logic [15:0] chan;
    logic [2:0]  slot;
    logic [2:0]  cmd;
  } cmd_word_t;

  typedef struct packed {
    logic        rej;
    logic [2:0]  wok_task;
    logic        wok_v;
    logic [31:0] slp_due;
    logic [2:0]  slp_task;
    logic        slp_v;
    logic        sw;
    logic [2:0]  cur;
  } res_word_t;

  localparam int IdlePct = 19;
  localparam int StallLimit = 4000;
  localparam int SettleCycles = 30;

  class sched_scoreboard;
    slot_state_t st[MaxTasks];
    logic [7:0]  pr[MaxTasks];
    logic [15:0] ch[MaxTasks];
    logic [31:0] du[MaxTasks];
    logic [2:0]  lk[MaxTasks];
    bit          lv[MaxTasks];
    logic [2:0]  run;
    logic [2:0]  armed;
    bit          armed_v;
    logic [2:0]  ord[MaxTasks];
    int          n_ord;
    res_word_t   pending_res[$];
    int          errors;
    int          n_checked;
    int          n_switch;
    int          n_reject;
    int          n_woken;

    function new();
      for (int i = 0; i < MaxTasks; i++) begin
        st[i] = ST_FREE;
        pr[i] = 0;
        ch[i] = 0;
        du[i] = 0;
        lk[i] = 0;
        lv[i] = 0;
      end
      st[0] = ST_ACTIVE;
      run = 0;
      armed = 0;
      armed_v = 0;
    endfunction

    function void set_main_priority(logic [7:0] v);
      pr[0] = v;
    endfunction

    function void walk();
      logic [2:0] s;
      s = 0;
      n_ord = 0;
      forever begin
        ord[n_ord] = s;
        n_ord++;
        if (n_ord >= MaxTasks || !lv[s]) break;
        s = lk[s];
      end
    endfunction

    function void rearm();
      bit found;
      logic [2:0] best;
      found = 0;
      best = 0;
      walk();
      for (int i = 0; i < n_ord; i++) begin
        if (st[ord[i]] == ST_SLEEP && (!found || du[ord[i]] < du[best])) begin
          best = ord[i];
          found = 1;
        end
      end
      armed_v = found;
      armed = found ? best : 3'd0;
    endfunction

    function bit resume(logic [2:0] t);
      slot_state_t old;
      old = st[t];
      if (old != ST_SLEEP && old != ST_WAIT) return 0;
      st[t] = ST_ACTIVE;
      if (old == ST_SLEEP && armed_v && armed == t) rearm();
      ch[t] = 0;
      if (pr[t] > pr[run] || st[run] != ST_ACTIVE) run = t;
      return 1;
    endfunction

    function void note_command(cmd_word_t w);
      res_word_t r;
      logic [2:0] prev, best;
      bit found;
      prev = run;
      r = '0;
      found = 0;
      best = 0;
      case (w.cmd)
        CMD_WAIT, CMD_SLEEP: begin
          ch[run] = w.chan;
          if (w.cmd == CMD_SLEEP) begin
            st[run] = ST_SLEEP;
            du[run] = w.due;
            rearm();
          end else begin
            st[run] = ST_WAIT;
          end
          walk();
          for (int i = 0; i < n_ord; i++) begin
            if (st[ord[i]] == ST_ACTIVE && (!found || pr[ord[i]] > pr[best])) begin
              best = ord[i];
              found = 1;
            end
          end
          if (found) run = best;
        end
        CMD_WAKE: begin
          if (resume(w.slot)) begin
            r.wok_v = 1;
            r.wok_task = w.slot;
          end
        end
        CMD_SIGNAL: begin
          walk();
          for (int i = 0; i < n_ord; i++) begin
            if ((st[ord[i]] == ST_SLEEP || st[ord[i]] == ST_WAIT) && ch[ord[i]] == w.chan &&
                (!found || pr[ord[i]] > pr[best])) begin
              best = ord[i];
              found = 1;
            end
          end
          if (found && resume(best)) begin
            r.wok_v = 1;
            r.wok_task = best;
          end
        end
        CMD_LAUNCH: begin
          if (st[w.slot] != ST_FREE) begin
            r.rej = 1;
          end else begin
            st[w.slot] = ST_ACTIVE;
            pr[w.slot] = w.prio;
            ch[w.slot] = 0;
            lk[w.slot] = lk[run];
            lv[w.slot] = lv[run];
            lk[run] = w.slot;
            lv[run] = 1;
            run = w.slot;
          end
        end
        default: ;
      endcase
      r.cur = run;
      r.sw = (run != prev);
      r.slp_v = armed_v;
      r.slp_task = armed_v ? armed : 3'd0;
      r.slp_due = armed_v ? du[armed] : 32'd0;
      pending_res.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
      end
    endfunction

    function void check_result(res_word_t a);
      res_word_t e;
      if (pending_res.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word %h", $time, a);
        return;
      end
      e = pending_res.pop_front();
      n_checked++;
      n_switch += a.sw;
      n_reject += a.rej;
      n_woken += a.wok_v;
      cmp("current_task", e.cur, a.cur);
      cmp("switched", e.sw, a.sw);
      cmp("sleeper_valid", e.slp_v, a.slp_v);
      cmp("sleeper_task", e.slp_task, a.slp_task);
      cmp("sleeper_due", e.slp_due, a.slp_due);
      cmp("woken_valid", e.wok_v, a.wok_v);
      cmp("woken_task", e.wok_task, a.wok_task);
      cmp("rejected", e.rej, a.rej);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n;
  bit   idle_on;
  int   quiet_cycles = 0;
  sched_scoreboard sched_sb;

  pts_if #(.W($bits(cmd_word_t))) in_ch();
  pts_if #(.W($bits(res_word_t))) out_ch();
  pts_if #(.W(8)) cfg_ch();

  priority_task_scheduler DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial sched_sb = new();

  // monitors, sink stalls and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) sched_sb.set_main_priority(cfg_ch.data);
      if (in_ch.valid && in_ch.ready) sched_sb.note_command(in_ch.data);
      if (out_ch.valid && out_ch.ready) sched_sb.check_result(out_ch.data);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
    out_ch.ready <= !(idle_on && $urandom_range(99) < IdlePct);
  end

  task automatic send_cmd(logic [2:0] cmd, logic [2:0] slot, logic [15:0] chan,
                          logic [31:0] due, logic [7:0] prio);
    cmd_word_t w;
    w.cmd = cmd;
    w.slot = slot;
    w.chan = chan;
    w.due = due;
    w.prio = prio;
    if (idle_on && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 0;
    @(posedge clk);
    while (sched_sb.pending_res.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_priority(logic [7:0] v);
    cfg_ch.valid <= 1;
    cfg_ch.data <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
  endtask

  task automatic random_cmd();
    int r;
    logic [2:0] slot;
    logic [7:0] prio;
    logic [15:0] chan;
    logic [31:0] due;
    r = $urandom_range(99);
    slot = 3'($urandom_range(7));
    prio = 8'($urandom_range(255));
    chan = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    due = ($urandom_range(3) == 0) ? 32'($urandom_range(15)) : $urandom;
    if (r < 20) send_cmd(CMD_LAUNCH, slot, chan, due, prio);
    else if (r < 35) send_cmd(CMD_WAIT, slot, chan, due, prio);
    else if (r < 50) send_cmd(CMD_SLEEP, slot, chan, due, prio);
    else if (r < 72) send_cmd(CMD_WAKE, slot, chan, due, prio);
    else if (r < 95) send_cmd(CMD_SIGNAL, slot, chan, due, prio);
    else send_cmd(3'($urandom_range(5, 7)), slot, chan, due, prio);
  endtask

  initial begin
    logic [7:0] prio_set[5];
    rst_n <= 0;
    idle_on = 1;
    in_ch.valid <= 0;
    in_ch.data <= '0;
    cfg_ch.valid <= 0;
    cfg_ch.data <= '0;
    prio_set = '{8'd255, 8'd0, 8'($urandom_range(1, 254)), 8'd128, 8'd1};
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    write_priority(prio_set[0]);
    send_cmd(3'd5, 3'd7, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF);
    send_cmd(3'd6, 3'd0, 16'h0, 32'h0, 8'h0);
    send_cmd(3'd7, 3'd5, 16'h1234, 32'h0, 8'h0);
    send_cmd(CMD_WAKE, 3'd3, 16'h0, 32'h0, 8'h0);
    send_cmd(CMD_WAKE, 3'd0, 16'h0, 32'h0, 8'h0);
    send_cmd(CMD_WAIT, 3'd0, 16'h0, 32'h0, 8'h0);
    send_cmd(CMD_SIGNAL, 3'd0, 16'h0, 32'h0, 8'h0);
    send_cmd(CMD_LAUNCH, 3'd1, 16'h0, 32'h0, 8'hFF);
    send_cmd(CMD_LAUNCH, 3'd1, 16'h0, 32'h0, 8'h10);
    send_cmd(CMD_LAUNCH, 3'd0, 16'h0, 32'h0, 8'h10);
    send_cmd(CMD_LAUNCH, 3'd7, 16'h0, 32'h0, 8'h00);
    send_cmd(CMD_SLEEP, 3'd0, 16'hFFFF, 32'hFFFF_FFFF, 8'h0);
    send_cmd(CMD_SLEEP, 3'd0, 16'h0, 32'h0, 8'h0);
    send_cmd(CMD_WAIT, 3'd0, 16'hFFFF, 32'h0, 8'h0);
    send_cmd(CMD_SIGNAL, 3'd0, 16'hFFFF, 32'h0, 8'h0);
    send_cmd(CMD_WAKE, 3'd1, 16'h0, 32'h0, 8'h0);
    send_cmd(CMD_WAKE, 3'd0, 16'h0, 32'h0, 8'h0);
    send_cmd(CMD_SIGNAL, 3'd0, 16'h0, 32'h0, 8'h0);
    send_cmd(CMD_LAUNCH, 3'd4, 16'h0, 32'h0, 8'h80);
    send_cmd(CMD_WAKE, 3'd4, 16'h0, 32'h0, 8'h0);

    for (int p = 1; p < 5; p++) begin
      settle();
      write_priority(prio_set[p]);
      idle_on = (p != 2);
      repeat (420) random_cmd();
    end
    idle_on = 1;

    settle();
    $display("checked %0d results: %0d task switches, %0d wakeups, %0d refused launches",
             sched_sb.n_checked, sched_sb.n_switch, sched_sb.n_woken, sched_sb.n_reject);
    $display("main priority settings: 255, 0, mid value, 128, 1");
    if (sched_sb.errors == 0 && sched_sb.pending_res.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== priority_task_scheduler.f =====
+incdir+rtl/core
rtl/core/pts_pkg.sv
rtl/core/pts_if.sv
rtl/core/pts_ctrl.sv
rtl/core/pts_dp.sv
rtl/core/priority_task_scheduler.sv
tb/tb_priority_task_scheduler.sv
